>>> rtl/tmic_pkg.sv
// Shared types and constants for the tape machine interpreter core.
// Holds the item, result and instruction codes and the controller/datapath
// command and status structs. No dependencies.
package tmic_pkg;

   localparam int TAPE_DEPTH  = 512;
   localparam int ADDR_BITS   = $clog2(TAPE_DEPTH);
   localparam int WORD_BITS   = 32;
   localparam int VALUE_BITS  = 32;
   localparam int OFS_BITS    = 3;
   localparam int INSTR_COUNT = 10;

   typedef enum logic [1:0] {
      ITEM_LOAD = 2'd0,
      ITEM_STEP = 2'd1,
      ITEM_READ = 2'd2,
      ITEM_NOP  = 2'd3
   } item_opcode_type;

   typedef enum logic [2:0] {
      KIND_ACK    = 3'd0,
      KIND_CHAR   = 3'd1,
      KIND_NUMBER = 3'd2,
      KIND_READ   = 3'd3,
      KIND_HALTED = 3'd4,
      KIND_STUCK  = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      INSTR_HALT      = 4'd0,
      INSTR_ADD       = 4'd1,
      INSTR_MUL       = 4'd2,
      INSTR_LESS      = 4'd3,
      INSTR_EQUAL     = 4'd4,
      INSTR_JUMP      = 4'd5,
      INSTR_JUMP_NZ   = 4'd6,
      INSTR_COPY      = 4'd7,
      INSTR_EMIT_CHAR = 4'd8,
      INSTR_EMIT_NUM  = 4'd9,
      INSTR_BAD       = 4'd15
   } instr_type;

   typedef enum logic [1:0] {
      ADDR_REQ,
      ADDR_PC,
      ADDR_IND
   } addr_sel_type;

   typedef enum logic [1:0] {
      PC_HOLD,
      PC_ADV,
      PC_JUMP
   } pc_sel_type;

   typedef enum logic [1:0] {
      RES_HOLD,
      RES_COPY,
      RES_ALU
   } res_sel_type;

   typedef enum logic [1:0] {
      VAL_ZERO,
      VAL_CHAR,
      VAL_WORD
   } val_sel_type;

   typedef enum logic {
      WD_REQ,
      WD_RESULT
   } wdata_sel_type;

   typedef struct packed {
      logic                latch_req;
      logic                mem_en;
      logic                mem_we;
      addr_sel_type        addr_sel;
      wdata_sel_type       wdata_sel;
      logic [OFS_BITS-1:0] pc_ofs;
      pc_sel_type          pc_sel;
      logic                latch_a;
      res_sel_type         res_sel;
      instr_type           alu_op;
      logic                set_halt;
      logic                set_kind;
      kind_type            kind;
      val_sel_type         val_sel;
      logic                deliver;
   } cmd_type;

   typedef struct packed {
      item_opcode_type req_opcode;
      logic            halted;
      logic            pc_last;
      instr_type       instr;
      logic            rdata_zero;
   } status_type;

endpackage

>>> rtl/tmic_dpath.sv
// Datapath of the tape machine core: tape memory, program counter, halt flag,
// operand and result registers, ALU and the result output register.
// Depends on tmic_pkg.
module tmic_dpath
   import tmic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  item_opcode_type       req_opcode,
   input  logic [ADDR_BITS-1:0]  req_address,
   input  logic [VALUE_BITS-1:0] req_data,
   output kind_type              rsp_kind,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic [ADDR_BITS-1:0]  rsp_pc,
   output logic                  rsp_halted
);

   logic [WORD_BITS-1:0]  mem [TAPE_DEPTH];
   logic [WORD_BITS-1:0]  rdata_ff;

   item_opcode_type       req_opcode_ff;
   logic [ADDR_BITS-1:0]  req_addr_ff;
   logic [WORD_BITS-1:0]  req_data_ff;

   logic [ADDR_BITS-1:0]  pc_ff, pc_in;
   logic                  halt_ff, halt_in;
   logic [WORD_BITS-1:0]  a_ff;
   logic [WORD_BITS-1:0]  result_ff, result_in;
   kind_type              kind_ff;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   kind_type              rsp_kind_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [ADDR_BITS-1:0]  rsp_pc_ff;
   logic                  rsp_halted_ff;

   logic [ADDR_BITS-1:0]  pc_plus;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic [WORD_BITS-1:0]  alu_out;
   logic [WORD_BITS-1:0]  product;

   assign pc_plus = pc_ff + ADDR_BITS'(cmd.pc_ofs);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_REQ: mem_addr = req_addr_ff;
         ADDR_PC:  mem_addr = pc_plus;
         default:  mem_addr = rdata_ff[ADDR_BITS-1:0];
      endcase
      mem_wdata = (cmd.wdata_sel == WD_REQ) ? req_data_ff : result_ff;
   end

   // single-port tape, read data registered
   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         if (cmd.mem_we) begin
            mem[mem_addr] <= mem_wdata;
         end
         rdata_ff <= mem[mem_addr];
      end
   end

   assign product = a_ff * rdata_ff;

   always_comb begin
      case (cmd.alu_op)
         INSTR_ADD:   alu_out = a_ff + rdata_ff;
         INSTR_MUL:   alu_out = product;
         INSTR_LESS:  alu_out = WORD_BITS'($signed(a_ff) < $signed(rdata_ff));
         INSTR_EQUAL: alu_out = WORD_BITS'(a_ff == rdata_ff);
         default:     alu_out = rdata_ff;
      endcase

      case (cmd.res_sel)
         RES_COPY: result_in = rdata_ff;
         RES_ALU:  result_in = alu_out;
         default:  result_in = result_ff;
      endcase

      case (cmd.val_sel)
         VAL_CHAR: value_in = VALUE_BITS'(rdata_ff[7:0]);
         VAL_WORD: value_in = VALUE_BITS'($signed(rdata_ff));
         default:  value_in = '0;
      endcase

      case (cmd.pc_sel)
         PC_ADV:  pc_in = pc_plus;
         PC_JUMP: pc_in = rdata_ff[ADDR_BITS-1:0];
         default: pc_in = pc_ff;
      endcase

      halt_in = halt_ff | cmd.set_halt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_opcode_ff <= req_opcode;
         req_addr_ff   <= req_address;
         req_data_ff   <= WORD_BITS'(req_data);
      end
      if (cmd.latch_a) begin
         a_ff <= rdata_ff;
      end
      result_ff <= result_in;
      if (cmd.set_kind) begin
         kind_ff  <= cmd.kind;
         value_ff <= value_in;
      end
      if (cmd.deliver) begin
         rsp_kind_ff   <= kind_ff;
         rsp_value_ff  <= value_ff;
         rsp_pc_ff     <= pc_ff;
         rsp_halted_ff <= halt_ff;
      end
   end

   always_comb begin
      status.req_opcode = req_opcode_ff;
      status.halted     = halt_ff;
      status.pc_last    = (pc_ff == ADDR_BITS'(TAPE_DEPTH - 1));
      status.instr      = (rdata_ff < WORD_BITS'(INSTR_COUNT)) ?
                          instr_type'(rdata_ff[3:0]) : INSTR_BAD;
      status.rdata_zero = (rdata_ff == '0);
   end

   assign rsp_kind   = rsp_kind_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_pc     = rsp_pc_ff;
   assign rsp_halted = rsp_halted_ff;

endmodule

>>> rtl/tmic_ctrl.sv
// Controller of the tape machine core: sequences tape accesses for each item
// and owns the input ready and the result valid. Depends on tmic_pkg.
module tmic_ctrl
   import tmic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_RDWAIT,
      S_FETCH,
      S_P1,
      S_A,
      S_P2,
      S_B,
      S_DST,
      S_J1,
      S_J2,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   instr_type op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.addr_sel = ADDR_PC;
      cmd.wdata_sel = WD_REQ;
      cmd.pc_sel   = PC_HOLD;
      cmd.res_sel  = RES_HOLD;
      cmd.alu_op   = op_ff;
      cmd.kind     = KIND_ACK;
      cmd.val_sel  = VAL_ZERO;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.req_opcode)
               ITEM_LOAD: begin
                  cmd.mem_en   = 1'b1;
                  cmd.mem_we   = 1'b1;
                  cmd.addr_sel = ADDR_REQ;
                  cmd.set_kind = 1'b1;
                  state_in     = S_FINISH;
               end
               ITEM_STEP: begin
                  if (status.halted) begin
                     cmd.set_kind = 1'b1;
                     cmd.kind     = KIND_HALTED;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.mem_en = 1'b1;
                     cmd.pc_ofs = OFS_BITS'(0);
                     state_in   = S_FETCH;
                  end
               end
               ITEM_READ: begin
                  cmd.mem_en   = 1'b1;
                  cmd.addr_sel = ADDR_REQ;
                  state_in     = S_RDWAIT;
               end
               ITEM_NOP: begin
                  cmd.set_kind = 1'b1;
                  state_in     = S_FINISH;
               end
            endcase
         end
         S_RDWAIT: begin
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_READ;
            cmd.val_sel  = VAL_WORD;
            state_in     = S_FINISH;
         end
         S_FETCH: begin
            if (status.instr == INSTR_HALT || status.pc_last) begin
               cmd.set_halt = 1'b1;
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_HALTED;
               state_in     = S_FINISH;
            end else if (status.instr == INSTR_BAD) begin
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_STUCK;
               state_in     = S_FINISH;
            end else begin
               op_in      = status.instr;
               cmd.mem_en = 1'b1;
               cmd.pc_ofs = OFS_BITS'(1);
               state_in   = S_P1;
            end
         end
         S_P1: begin
            cmd.mem_en   = 1'b1;
            cmd.addr_sel = ADDR_IND;
            state_in     = S_A;
         end
         S_A: begin
            // read data holds the first indirect operand
            unique case (op_ff) inside
               INSTR_JUMP: begin
                  cmd.pc_sel   = PC_JUMP;
                  cmd.set_kind = 1'b1;
                  state_in     = S_FINISH;
               end
               INSTR_EMIT_CHAR: begin
                  cmd.pc_sel   = PC_ADV;
                  cmd.pc_ofs   = OFS_BITS'(2);
                  cmd.set_kind = 1'b1;
                  cmd.kind     = KIND_CHAR;
                  cmd.val_sel  = VAL_CHAR;
                  state_in     = S_FINISH;
               end
               INSTR_EMIT_NUM: begin
                  cmd.pc_sel   = PC_ADV;
                  cmd.pc_ofs   = OFS_BITS'(2);
                  cmd.set_kind = 1'b1;
                  cmd.kind     = KIND_NUMBER;
                  cmd.val_sel  = VAL_WORD;
                  state_in     = S_FINISH;
               end
               INSTR_JUMP_NZ: begin
                  if (status.rdata_zero) begin
                     cmd.pc_sel   = PC_ADV;
                     cmd.pc_ofs   = OFS_BITS'(3);
                     cmd.set_kind = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.mem_en = 1'b1;
                     cmd.pc_ofs = OFS_BITS'(2);
                     state_in   = S_J1;
                  end
               end
               INSTR_COPY: begin
                  cmd.res_sel = RES_COPY;
                  cmd.mem_en  = 1'b1;
                  cmd.pc_ofs  = OFS_BITS'(2);
                  state_in    = S_DST;
               end
               INSTR_ADD, INSTR_MUL, INSTR_LESS, INSTR_EQUAL: begin
                  cmd.latch_a = 1'b1;
                  cmd.mem_en  = 1'b1;
                  cmd.pc_ofs  = OFS_BITS'(2);
                  state_in    = S_P2;
               end
               default: begin
                  cmd.set_kind = 1'b1;
                  state_in     = S_FINISH;
               end
            endcase
         end
         S_P2: begin
            cmd.mem_en   = 1'b1;
            cmd.addr_sel = ADDR_IND;
            state_in     = S_B;
         end
         S_B: begin
            cmd.res_sel = RES_ALU;
            cmd.mem_en  = 1'b1;
            cmd.pc_ofs  = OFS_BITS'(3);
            state_in    = S_DST;
         end
         S_DST: begin
            // read data holds the destination pointer
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ADDR_IND;
            cmd.wdata_sel = WD_RESULT;
            cmd.pc_sel    = PC_ADV;
            cmd.pc_ofs    = (op_ff == INSTR_COPY) ? OFS_BITS'(3) : OFS_BITS'(4);
            cmd.set_kind  = 1'b1;
            state_in      = S_FINISH;
         end
         S_J1: begin
            cmd.mem_en   = 1'b1;
            cmd.addr_sel = ADDR_IND;
            state_in     = S_J2;
         end
         S_J2: begin
            cmd.pc_sel   = PC_JUMP;
            cmd.set_kind = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.deliver  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= INSTR_HALT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/tape_machine_interpreter_core.sv
// Tape machine interpreter core, top level. Items are taken one at a time, each run to
// completion before the next is accepted; a step with an arithmetic instruction takes
// longest. The single-port tape serves one read or write per cycle.
// A finished result waits in the output register while the next item is accepted,
// and the one after it stalls until it drains.
// Synchronous active-high reset clears pc, halt flag and control, not the tape.
module tape_machine_interpreter_core
   import tmic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // address [8:0], data [40:9], zero pad
   input  logic [1:0]  req_tuser,  // opcode [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // value [31:0], pc [40:32], halted [41], zero pad
   output logic [2:0]  rsp_tuser   // kind [2:0]
);

   cmd_type               cmd;
   status_type            status;
   kind_type              rsp_kind;
   logic [VALUE_BITS-1:0] rsp_value;
   logic [ADDR_BITS-1:0]  rsp_pc;
   logic                  rsp_halted;

   // controller: walks each item through its tape accesses
   tmic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: tape, pc, halt flag, ALU, result register
   tmic_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_opcode  (item_opcode_type'(req_tuser)),
      .req_address (req_tdata[ADDR_BITS-1:0]),
      .req_data    (req_tdata[ADDR_BITS+VALUE_BITS-1:ADDR_BITS]),
      .rsp_kind    (rsp_kind),
      .rsp_value   (rsp_value),
      .rsp_pc      (rsp_pc),
      .rsp_halted  (rsp_halted)
   );

   // pack the result item, pad the upper bytes with zeros
   assign rsp_tdata = {6'b0, rsp_halted, rsp_pc, rsp_value};
   assign rsp_tuser = rsp_kind;

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in flight");

   // halt flag is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halt flag cleared without reset");

endmodule
